[rtl/core/dswd_pkg.sv]
// ----------------------------------------------------------------------------
// dswd_pkg: shared types and constants for the date span day counter
// Field widths, calendar tables, reciprocal constants, sequencer states and
// the payload structs of the three channels.
// ----------------------------------------------------------------------------
package dswd_pkg;

  // field widths
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned WD_W   = 3;
  localparam int unsigned CNT_W  = 22;
  localparam int unsigned MASK_W = 7;

  // internal widths
  localparam int unsigned R100_W = 7;   // year mod 100
  localparam int unsigned R400_W = 9;   // year mod 400
  localparam int unsigned Q100_W = 8;   // year div 100
  localparam int unsigned Q400_W = 6;   // year div 400
  localparam int unsigned SUM_W  = 16;  // weekday congruence sum
  localparam int unsigned PROD_W = YEAR_W + 10;

  // calendar limits
  localparam int unsigned MAX_YEAR   = 9999;
  localparam int unsigned YEARS_CENT = 100;
  localparam int unsigned YEARS_QUAD = 400;
  localparam int unsigned WEEK_DAYS  = 7;

  localparam logic [MON_W-1:0]  MON_JAN   = MON_W'(1);
  localparam logic [MON_W-1:0]  MON_MAR   = MON_W'(3);
  localparam logic [MON_W-1:0]  MON_DEC   = MON_W'(12);
  localparam logic [WD_W-1:0]   WD_LAST   = WD_W'(6);
  localparam logic [R100_W-1:0] R100_LAST = R100_W'(99);
  localparam logic [R400_W-1:0] R400_LAST = R400_W'(399);
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  localparam logic [MASK_W-1:0] WEEKEND_MASK_RST = MASK_W'(96);

  // reciprocal multipliers: x/25 and x/7 for the value ranges in use
  localparam int unsigned DIV25_MUL = 1311;
  localparam int unsigned DIV25_SH  = 15;
  localparam int unsigned DIV7_MUL  = 18725;
  localparam int unsigned DIV7_SH   = 17;

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } date_t;

  typedef struct packed {
    logic [DAY_W-1:0]  start_day;
    logic [MON_W-1:0]  start_month;
    logic [YEAR_W-1:0] start_year;
    logic [DAY_W-1:0]  end_day;
    logic [MON_W-1:0]  end_month;
    logic [YEAR_W-1:0] end_year;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] weekend_days;
    logic [CNT_W-1:0] business_days;
    logic [WD_W-1:0]  start_weekday;
    logic [WD_W-1:0]  end_weekday;
    logic             status;
  } res_t;

  typedef struct packed {
    logic [MASK_W-1:0] weekend_mask;
  } cfg_t;

  // what the calendar unit reports about one date
  typedef struct packed {
    logic              ok;
    logic [WD_W-1:0]   weekday;
    logic [R100_W-1:0] r100;
    logic [R400_W-1:0] r400;
  } cal_info_t;

  typedef struct packed {
    logic load;
    logic step;
  } walk_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC_S,
    ST_WAIT_S,
    ST_CALC_E,
    ST_WAIT_E,
    ST_DECIDE,
    ST_WALK,
    ST_FINISH
  } seq_state_t;

  // leap rule from the low year bits and the year residues
  function automatic logic is_leap(input logic [1:0] y_lo,
                                   input logic [R100_W-1:0] r100,
                                   input logic [R400_W-1:0] r400);
    return (r400 == '0) || ((y_lo == 2'b00) && (r100 != '0));
  endfunction

  // days in a month, zero for a month code outside the year
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:    len = leap ? DAY_W'(29) : DAY_W'(28);
      default: len = '0;
    endcase
    return len;
  endfunction

  // floor(31 * mm / 12) for the March based month
  function automatic logic [DAY_W-1:0] month_offset(input logic [MON_W-1:0] mm);
    logic [DAY_W-1:0] ofs;
    unique case (mm)
      4'd1:    ofs = DAY_W'(2);
      4'd2:    ofs = DAY_W'(5);
      4'd3:    ofs = DAY_W'(7);
      4'd4:    ofs = DAY_W'(10);
      4'd5:    ofs = DAY_W'(12);
      4'd6:    ofs = DAY_W'(15);
      4'd7:    ofs = DAY_W'(18);
      4'd8:    ofs = DAY_W'(20);
      4'd9:    ofs = DAY_W'(23);
      4'd10:   ofs = DAY_W'(25);
      4'd11:   ofs = DAY_W'(28);
      4'd12:   ofs = DAY_W'(31);
      default: ofs = '0;
    endcase
    return ofs;
  endfunction

endpackage

[rtl/core/dswd_chan_if.sv]
// ----------------------------------------------------------------------------
// dswd_chan_if: valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface dswd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/dswd_calc.sv]
// ----------------------------------------------------------------------------
// dswd_calc: calendar unit
// Three-stage pipeline giving validity, weekday and year residues of a date.
// Shared by the start and the end date of an item.
// ----------------------------------------------------------------------------
module dswd_calc
  import dswd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  date_t     in_date,
  output logic      out_valid,
  output cal_info_t out_info
);

  // march based year and month
  logic              shift_early;
  logic [YEAR_W-1:0] yy;
  logic [MON_W-1:0]  mm;
  logic [PROD_W-1:0] p100;
  logic [PROD_W-1:0] p400;

  assign shift_early = (in_date.month < MON_MAR);
  assign yy = shift_early ? in_date.year - YEAR_W'(1) : in_date.year;
  assign mm = shift_early ? in_date.month + MON_W'(10) : in_date.month - MON_W'(2);

  // yy/100 = (yy/4)/25 and yy/400 = (yy/16)/25 by reciprocal
  assign p100 = PROD_W'(yy[YEAR_W-1:2]) * PROD_W'(DIV25_MUL);
  assign p400 = PROD_W'(yy[YEAR_W-1:4]) * PROD_W'(DIV25_MUL);

  logic              v1_r;
  logic [DAY_W-1:0]  d1_r;
  logic [MON_W-1:0]  mo1_r;
  logic [YEAR_W-1:0] y1_r;
  logic [YEAR_W-1:0] yy1_r;
  logic [MON_W-1:0]  mm1_r;
  logic              shift1_r;
  logic [Q100_W-1:0] q100_1_r;
  logic [Q400_W-1:0] q400_1_r;

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    d1_r     <= in_date.day;
    mo1_r    <= in_date.month;
    y1_r     <= in_date.year;
    yy1_r    <= yy;
    mm1_r    <= mm;
    shift1_r <= shift_early;
    q100_1_r <= Q100_W'(p100 >> DIV25_SH);
    q400_1_r <= Q400_W'(p400 >> DIV25_SH);
  end

  // residues of the shifted year, moved back to the calendar year
  logic [YEAR_W-1:0] rem100_full;
  logic [YEAR_W-1:0] rem400_full;
  logic [R100_W-1:0] r100_yy;
  logic [R400_W-1:0] r400_yy;
  logic [R100_W-1:0] r100_y;
  logic [R400_W-1:0] r400_y;
  logic              leap;
  logic [SUM_W-1:0]  wd_sum;
  logic              date_ok;

  assign rem100_full = yy1_r - YEAR_W'(q100_1_r) * YEAR_W'(YEARS_CENT);
  assign rem400_full = yy1_r - YEAR_W'(q400_1_r) * YEAR_W'(YEARS_QUAD);
  assign r100_yy     = rem100_full[R100_W-1:0];
  assign r400_yy     = rem400_full[R400_W-1:0];

  assign r100_y = !shift1_r ? r100_yy :
                  (r100_yy == R100_LAST) ? '0 : r100_yy + R100_W'(1);
  assign r400_y = !shift1_r ? r400_yy :
                  (r400_yy == R400_LAST) ? '0 : r400_yy + R400_W'(1);
  assign leap   = is_leap(y1_r[1:0], r100_y, r400_y);

  // congruence sum before the mod 7
  assign wd_sum = SUM_W'(d1_r) + SUM_W'(yy1_r) + SUM_W'(yy1_r[YEAR_W-1:2])
                - SUM_W'(q100_1_r) + SUM_W'(q400_1_r) + SUM_W'(month_offset(mm1_r));

  assign date_ok = (d1_r != '0) && (d1_r <= month_len(mo1_r, leap))
                && (y1_r != '0) && (32'(y1_r) <= MAX_YEAR);

  logic              v2_r;
  logic [SUM_W-1:0]  sum2_r;
  logic [R100_W-1:0] r100_2_r;
  logic [R400_W-1:0] r400_2_r;
  logic              ok2_r;

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    sum2_r   <= wd_sum;
    r100_2_r <= r100_y;
    r400_2_r <= r400_y;
    ok2_r    <= date_ok;
  end

  // sum/7 by reciprocal
  logic [2*SUM_W-1:0] p7;

  assign p7 = (2*SUM_W)'(sum2_r) * (2*SUM_W)'(DIV7_MUL);

  logic              v3_r;
  logic [SUM_W-1:0]  sum3_r;
  logic [SUM_W-1:0]  q7_3_r;
  logic [R100_W-1:0] r100_3_r;
  logic [R400_W-1:0] r400_3_r;
  logic              ok3_r;

  // stage 3 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    sum3_r   <= sum2_r;
    q7_3_r   <= SUM_W'(p7 >> DIV7_SH);
    r100_3_r <= r100_2_r;
    r400_3_r <= r400_2_r;
    ok3_r    <= ok2_r;
  end

  // remainder gives the weekday
  logic [SUM_W-1:0] wd_rem;

  assign wd_rem = sum3_r - q7_3_r * SUM_W'(WEEK_DAYS);

  assign out_valid        = v3_r;
  assign out_info.ok      = ok3_r;
  assign out_info.weekday = wd_rem[WD_W-1:0];
  assign out_info.r100    = r100_3_r;
  assign out_info.r400    = r400_3_r;

endmodule

[rtl/core/dswd_walk.sv]
// ----------------------------------------------------------------------------
// dswd_walk: day stepping unit
// Advances a date and its weekday by one day per step and tallies each day
// as weekend or business day under the weekend mask.
// ----------------------------------------------------------------------------
module dswd_walk
  import dswd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  walk_ctrl_t        ctrl,
  input  date_t             start_date,
  input  date_t             end_date,
  input  logic [WD_W-1:0]   start_weekday,
  input  logic [R100_W-1:0] start_r100,
  input  logic [R400_W-1:0] start_r400,
  input  logic [MASK_W-1:0] weekend_mask,
  output logic              at_end,
  output logic [CNT_W-1:0]  weekend_days,
  output logic [CNT_W-1:0]  business_days
);

  date_t             walk_date_r,    walk_date_nxt;
  logic [WD_W-1:0]   walk_weekday_r, walk_weekday_nxt;
  logic [R100_W-1:0] r100_r,         r100_nxt;
  logic [R400_W-1:0] r400_r,         r400_nxt;
  logic [CNT_W-1:0]  weekend_tally_r,  weekend_tally_nxt;
  logic [CNT_W-1:0]  business_tally_r, business_tally_nxt;

  logic leap;
  logic last_day;
  logic last_month;

  assign leap       = is_leap(walk_date_r.year[1:0], r100_r, r400_r);
  assign last_day   = (walk_date_r.day == month_len(walk_date_r.month, leap));
  assign last_month = (walk_date_r.month == MON_DEC);
  assign at_end     = (walk_date_r == end_date);

  // load or advance one day
  always_comb begin
    walk_date_nxt      = walk_date_r;
    walk_weekday_nxt   = walk_weekday_r;
    r100_nxt           = r100_r;
    r400_nxt           = r400_r;
    weekend_tally_nxt  = weekend_tally_r;
    business_tally_nxt = business_tally_r;
    if (ctrl.load) begin
      walk_date_nxt      = start_date;
      walk_weekday_nxt   = start_weekday;
      r100_nxt           = start_r100;
      r400_nxt           = start_r400;
      weekend_tally_nxt  = '0;
      business_tally_nxt = '0;
    end else if (ctrl.step) begin
      if (last_day) begin
        walk_date_nxt.day = DAY_W'(1);
        if (last_month) begin
          walk_date_nxt.month = MON_JAN;
          walk_date_nxt.year  = walk_date_r.year + YEAR_W'(1);
          r100_nxt = (r100_r == R100_LAST) ? '0 : r100_r + R100_W'(1);
          r400_nxt = (r400_r == R400_LAST) ? '0 : r400_r + R400_W'(1);
        end else begin
          walk_date_nxt.month = walk_date_r.month + MON_W'(1);
        end
      end else begin
        walk_date_nxt.day = walk_date_r.day + DAY_W'(1);
      end
      walk_weekday_nxt = (walk_weekday_r == WD_LAST) ? '0 : walk_weekday_r + WD_W'(1);
      // tally the day being left, saturating
      if (weekend_mask[walk_weekday_r]) begin
        if (weekend_tally_r != CNT_MAX) weekend_tally_nxt = weekend_tally_r + CNT_W'(1);
      end else begin
        if (business_tally_r != CNT_MAX) business_tally_nxt = business_tally_r + CNT_W'(1);
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_date_r      <= '0;
      walk_weekday_r   <= '0;
      r100_r           <= '0;
      r400_r           <= '0;
      weekend_tally_r  <= '0;
      business_tally_r <= '0;
    end else begin
      walk_date_r      <= walk_date_nxt;
      walk_weekday_r   <= walk_weekday_nxt;
      r100_r           <= r100_nxt;
      r400_r           <= r400_nxt;
      weekend_tally_r  <= weekend_tally_nxt;
      business_tally_r <= business_tally_nxt;
    end
  end

  assign weekend_days  = weekend_tally_r;
  assign business_days = business_tally_r;

endmodule

[rtl/core/date_span_weekend_day_counter_unit.sv]
// ----------------------------------------------------------------------------
// date_span_weekend_day_counter_unit: weekend and business days in a span
// Sequence: after input accept the start and end dates pass the calendar unit
//   in turn, then the days from start to end are walked; an empty or invalid
//   span skips the walk and goes straight to the result.
// Throughput: one item at a time; the day walk steps one day per cycle, so
//   the walk loop sets the rate. A new item is taken once the result is in
//   the output register, while it still waits to be taken.
// Reset: synchronous, active low; returns to idle, mask to Friday/Saturday.
// ----------------------------------------------------------------------------
module date_span_weekend_day_counter_unit
  import dswd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  dswd_chan_if.sink    in_ch,
  dswd_chan_if.source  out_ch,
  dswd_chan_if.sink    cfg_ch
);

  seq_state_t        state_r, state_nxt;
  req_t              req_r;
  logic [MASK_W-1:0] mask_r;
  cal_info_t         sinfo_r;
  cal_info_t         einfo_r;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;

  logic       calc_go;
  date_t      calc_date;
  logic       calc_valid;
  cal_info_t  calc_info;
  walk_ctrl_t walk_ctrl;
  logic       walk_at_end;
  logic [CNT_W-1:0] walk_weekend;
  logic [CNT_W-1:0] walk_business;
  logic       res_load;
  logic       sinfo_en;
  logic       einfo_en;

  date_t start_date;
  date_t end_date;
  logic  dates_ok;
  logic  span_pos;

  assign start_date = '{day: req_r.start_day, month: req_r.start_month,
                        year: req_r.start_year};
  assign end_date   = '{day: req_r.end_day, month: req_r.end_month,
                        year: req_r.end_year};
  assign dates_ok   = sinfo_r.ok && einfo_r.ok;
  assign span_pos   = ({start_date.year, start_date.month, start_date.day}
                     < {end_date.year, end_date.month, end_date.day});

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // calendar unit, start date first then end date
  assign calc_date = (state_r == ST_CALC_E) ? end_date : start_date;

  dswd_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (calc_go),
    .in_date   (calc_date),
    .out_valid (calc_valid),
    .out_info  (calc_info)
  );

  dswd_walk u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (walk_ctrl),
    .start_date    (start_date),
    .end_date      (end_date),
    .start_weekday (sinfo_r.weekday),
    .start_r100    (sinfo_r.r100),
    .start_r400    (sinfo_r.r400),
    .weekend_mask  (mask_r),
    .at_end        (walk_at_end),
    .weekend_days  (walk_weekend),
    .business_days (walk_business)
  );

  // sequencer next state and controls
  always_comb begin
    state_nxt = state_r;
    calc_go   = 1'b0;
    walk_ctrl = '0;
    res_load  = 1'b0;
    sinfo_en  = 1'b0;
    einfo_en  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_CALC_S;
      end
      ST_CALC_S: begin
        calc_go   = 1'b1;
        state_nxt = ST_WAIT_S;
      end
      ST_WAIT_S: begin
        if (calc_valid) begin
          sinfo_en  = 1'b1;
          state_nxt = ST_CALC_E;
        end
      end
      ST_CALC_E: begin
        calc_go   = 1'b1;
        state_nxt = ST_WAIT_E;
      end
      ST_WAIT_E: begin
        if (calc_valid) begin
          einfo_en  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (dates_ok && span_pos) begin
          walk_ctrl.load = 1'b1;
          state_nxt      = ST_WALK;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_WALK: begin
        if (walk_at_end) begin
          state_nxt = ST_FINISH;
        end else begin
          walk_ctrl.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // result item
  always_comb begin
    res_nxt = '0;
    if (!dates_ok) begin
      res_nxt.status = 1'b1;
    end else begin
      res_nxt.start_weekday = sinfo_r.weekday;
      res_nxt.end_weekday   = einfo_r.weekday;
      if (span_pos) begin
        res_nxt.weekend_days  = walk_weekend;
        res_nxt.business_days = walk_business;
      end
    end
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mask_r      <= WEEKEND_MASK_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) mask_r <= cfg_ch.data.weekend_mask;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) req_r <= in_ch.data;
    if (sinfo_en) sinfo_r <= calc_info;
    if (einfo_en) einfo_r <= calc_info;
    if (res_load) res_r <= res_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

`ifndef ASSERT_OFF
  // an invalid date carries no counts and no weekdays
  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.status |->
      (out_ch.data.weekend_days == '0) && (out_ch.data.business_days == '0)
      && (out_ch.data.start_weekday == '0) && (out_ch.data.end_weekday == '0))
    else $error("error result with nonzero fields");

  // weekdays from the calendar unit stay in range
  a_wd_range: assert property (@(posedge clk) disable iff (!rst_n)
    calc_valid |-> (calc_info.weekday <= WD_LAST))
    else $error("weekday out of range");

  // calendar results arrive only while the sequencer waits for them
  a_calc_window: assert property (@(posedge clk) disable iff (!rst_n)
    calc_valid |-> (state_r == ST_WAIT_S) || (state_r == ST_WAIT_E))
    else $error("calendar result outside wait state");

  // the walk runs only over a valid, non-empty span
  a_walk_span: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> dates_ok && span_pos)
    else $error("walk on invalid or empty span");
`endif

endmodule

[tb/tb_date_span_weekend_day_counter_unit.sv]
// ----------------------------------------------------------------------------
// tb_date_span_weekend_day_counter_unit: self-checking bench for the day counter
// Drives date spans through the request channel and writes the weekend mask
// between phases while the block is idle. Each result is checked against a
// calendar predictor built on day ordinals. Sender gaps and receiver stalls
// are random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_date_span_weekend_day_counter_unit;
  import dswd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LAST_YEAR      = 9999;
  localparam int unsigned COUNT_CEIL     = (1 << CNT_W) - 1;
  localparam int          REQ_W          = $bits(req_t);
  localparam int          RANDOM_PHASES  = 6;
  localparam int          PHASE_ITEMS    = 250;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          REPORT_LIMIT   = 10;
  localparam int          TAIL_CYCLES    = 40;
  // longest walk here is about 146100 days, taken a few times over
  localparam int          WATCHDOG_LIMIT = 600000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dswd_chan_if #(.payload_t(req_t)) req_if ();
  dswd_chan_if #(.payload_t(res_t)) res_if ();
  dswd_chan_if #(.payload_t(cfg_t)) mask_if ();

  date_span_weekend_day_counter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if),
    .cfg_ch (mask_if)
  );

  // predictor state and run bookkeeping
  logic [MASK_W-1:0] weekend_sel = WEEKEND_MASK_RST;
  res_t              expected_results[$];
  bit                idling = 1'b1;
  int                hold_requests = 0;
  int                fault_count = 0;
  int                results_seen = 0;
  int                requests_sent = 0;
  int                invalid_sent = 0;
  int                empty_sent = 0;
  int                longest_span = 0;
  int                mask_writes = 0;

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // calendar predictor
  // ---------------------------------------------------------------------------
  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_of_month(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic bit date_valid(int unsigned d, int unsigned m, int unsigned y);
    return (y >= 1) && (y <= LAST_YEAR) && (d >= 1) && (d <= days_of_month(y, m));
  endfunction

  // day count with 1 Jan of year 1 as day 1, a Monday, so mod 7 is the weekday
  function automatic int unsigned day_ordinal(int unsigned d, int unsigned m,
                                              int unsigned y);
    int unsigned py;
    int unsigned n;
    py = y - 1;
    n  = 365 * py + py / 4 - py / 100 + py / 400;
    for (int unsigned k = 1; k < m; k++) n += days_of_month(y, k);
    return n + d;
  endfunction

  function automatic res_t predict_day_counts(req_t r);
    res_t        p;
    int unsigned os, oe, span, sw, cnt, wk, bz;
    p = '0;
    if (!date_valid(r.start_day, r.start_month, r.start_year) ||
        !date_valid(r.end_day, r.end_month, r.end_year)) begin
      p.status = 1'b1;
      return p;
    end
    os   = day_ordinal(r.start_day, r.start_month, r.start_year);
    oe   = day_ordinal(r.end_day, r.end_month, r.end_year);
    sw   = os % 7;
    span = (oe > os) ? oe - os : 0;
    wk   = 0;
    bz   = 0;
    // whole weeks give every weekday once, the partial week starts at sw
    for (int k = 0; k < 7; k++) begin
      cnt = span / 7 + ((((k + 7 - sw) % 7) < span % 7) ? 1 : 0);
      if (weekend_sel[k]) wk += cnt;
      else bz += cnt;
    end
    p.weekend_days  = CNT_W'((wk > COUNT_CEIL) ? COUNT_CEIL : wk);
    p.business_days = CNT_W'((bz > COUNT_CEIL) ? COUNT_CEIL : bz);
    p.start_weekday = WD_W'(sw);
    p.end_weekday   = WD_W'(oe % 7);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------
  function automatic req_t span_of(int unsigned sd, int unsigned sm, int unsigned sy,
                                   int unsigned ed, int unsigned em, int unsigned ey);
    req_t r;
    r.start_day   = DAY_W'(sd);
    r.start_month = MON_W'(sm);
    r.start_year  = YEAR_W'(sy);
    r.end_day     = DAY_W'(ed);
    r.end_month   = MON_W'(em);
    r.end_year    = YEAR_W'(ey);
    return r;
  endfunction

  function automatic date_t pick_date();
    date_t       t;
    int unsigned y, m;
    case ($urandom_range(0, 9))
      0:       y = $urandom_range(1, 99) * 100;
      1:       y = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
      default: y = $urandom_range(1, LAST_YEAR);
    endcase
    m       = $urandom_range(1, 12);
    t.year  = YEAR_W'(y);
    t.month = MON_W'(m);
    t.day   = DAY_W'($urandom_range(1, days_of_month(y, m)));
    return t;
  endfunction

  // moves a date on by n days; may run past the last year, which is then invalid
  function automatic date_t step_days(date_t s, int unsigned n);
    int unsigned d, m, y;
    d = s.day;
    m = s.month;
    y = s.year;
    repeat (n) begin
      d++;
      if (d > days_of_month(y, m)) begin
        d = 1;
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
    end
    s.day   = DAY_W'(d);
    s.month = MON_W'(m);
    s.year  = YEAR_W'(y);
    return s;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    date_t       a, b, t;
    int unsigned pick, n, len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // raw noise over every field bit, both dates in one year to keep walks short
      r = REQ_W'({$urandom, $urandom});
      r.end_year = r.start_year;
      return r;
    end
    a = pick_date();
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(61, 800) : $urandom_range(0, 60);
    b = step_days(a, n);
    if (pick >= 14 && pick < 24) begin
      // start at or after the end
      t = a;
      a = b;
      b = t;
    end
    r = span_of(a.day, a.month, a.year, b.day, b.month, b.year);
    if (pick >= 8 && pick < 14) begin
      // one field broken in an otherwise sound span
      len = days_of_month(r.end_year, r.end_month);
      case ($urandom_range(0, 3))
        0: r.start_month = $urandom_range(0, 1) ? MON_W'(0) : MON_W'($urandom_range(13, 15));
        1: r.end_day = (len < 31 && $urandom_range(0, 1)) ?
                       DAY_W'($urandom_range(len + 1, 31)) : DAY_W'(0);
        2: r.start_year = $urandom_range(0, 1) ? YEAR_W'(0) :
                          YEAR_W'($urandom_range(10000, 16383));
        default: r.end_month = $urandom_range(0, 1) ? MON_W'(0) : MON_W'($urandom_range(13, 15));
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------
  // leaves valid high after the handshake so items can go back to back
  task automatic send_span(req_t r);
    res_t want;
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_if.data  = r;
    req_if.valid = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    want = predict_day_counts(r);
    expected_results.push_back(want);
    requests_sent++;
    if (want.status) invalid_sent++;
    else if (want.weekend_days + want.business_days == 0) empty_sent++;
    else if (int'(want.weekend_days + want.business_days) > longest_span)
      longest_span = want.weekend_days + want.business_days;
  endtask

  // drops the request valid and waits for every outstanding result
  task automatic settle_block();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_weekend_mask(logic [MASK_W-1:0] m);
    settle_block();
    @(negedge clk);
    mask_if.data.weekend_mask = m;
    mask_if.valid = 1'b1;
    do @(posedge clk); while (!mask_if.ready);
    weekend_sel = m;
    mask_writes++;
    @(negedge clk);
    mask_if.valid = 1'b0;
  endtask

  // result receiver: random stalls plus an occasional long hold-off
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int holds_seen;
    stall_left   = 0;
    hold_left    = 0;
    holds_seen   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready = 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(1, 6) - 1;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got)
      note_fault($sformatf("result %0d %s expected %0d got %0d",
                           results_seen, name, want, got));
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    res_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = res_if.data;
      results_seen++;
      if (expected_results.size() == 0) begin
        note_fault($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = expected_results.pop_front();
        check_field("weekend_days", want.weekend_days, got.weekend_days);
        check_field("business_days", want.business_days, got.business_days);
        check_field("start_weekday", want.start_weekday, got.start_weekday);
        check_field("end_weekday", want.end_weekday, got.end_weekday);
        check_field("status", want.status, got.status);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin : watchdog
    int stuck;
    if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (mask_if.valid && mask_if.ready)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 stuck, expected_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // field extremes, leap rules and invalid dates under the reset mask
  task automatic test_calendar_edges();
    send_span(span_of(1, 1, 1, 2, 1, 1));
    send_span(span_of(1, 1, 1, 1, 1, 2));
    send_span(span_of(31, 12, 9999, 31, 12, 9999));
    send_span(span_of(30, 12, 9999, 31, 12, 9999));
    send_span(span_of(28, 2, 2000, 1, 3, 2000));
    send_span(span_of(28, 2, 1900, 1, 3, 1900));
    send_span(span_of(28, 2, 2024, 1, 3, 2024));
    send_span(span_of(29, 2, 2000, 1, 3, 2000));
    send_span(span_of(31, 1, 2023, 31, 12, 2023));
    send_span(span_of(1, 3, 2024, 1, 3, 2023));
    send_span(span_of(29, 2, 1900, 1, 3, 1900));
    send_span(span_of(30, 2, 2000, 1, 3, 2000));
    send_span(span_of(1, 4, 2021, 31, 4, 2021));
    send_span(span_of(0, 5, 2021, 3, 5, 2021));
    send_span(span_of(1, 0, 2021, 3, 5, 2021));
    send_span(span_of(1, 5, 2021, 3, 13, 2021));
    send_span(span_of(1, 5, 2021, 3, 15, 2021));
    send_span(span_of(1, 1, 0, 3, 1, 1));
    send_span(span_of(1, 1, 9999, 1, 1, 10000));
    send_span(span_of(31, 15, 16383, 31, 15, 16383));
    send_span(span_of(31, 12, 1999, 1, 1, 2000));
    settle_block();
  endtask

  // mask extremes and single days, each over spans starting on every weekday
  task automatic test_weekend_settings();
    logic [MASK_W-1:0] masks[6];
    masks = '{7'h00, 7'h7f, 7'h01, 7'h40, 7'h55, 7'h2a};
    foreach (masks[i]) begin
      write_weekend_mask(masks[i]);
      for (int j = 0; j < 7; j++) send_span(span_of(1 + j, 1, 2024, 10 + 2 * j, 1, 2024));
    end
  endtask

  // whole 400-year cycles, one at each end of the year range
  task automatic test_century_spans();
    write_weekend_mask(7'h41);
    send_span(span_of(1, 1, 1, 1, 1, 401));
    send_span(span_of(1, 1, 9600, 31, 12, 9999));
    settle_block();
  endtask

  // receiver holds off while short spans keep coming
  task automatic test_output_backpressure();
    idling = 1'b0;
    hold_requests++;
    for (int i = 0; i < 8; i++) send_span(span_of(5, 6, 2020, 5 + (i % 3), 6, 2020));
    settle_block();
    idling = 1'b1;
  endtask

  task automatic test_random_spans();
    logic [MASK_W-1:0] m;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1:       m = 7'h00;
        2:       m = 7'h7f;
        5:       m = WEEKEND_MASK_RST;
        default: m = MASK_W'($urandom);
      endcase
      write_weekend_mask(m);
      // the last phase runs with no gaps on either side
      idling = (ph != RANDOM_PHASES - 1);
      repeat (PHASE_ITEMS) send_span(random_request());
    end
    settle_block();
  endtask

  initial begin
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    mask_if.valid = 1'b0;
    mask_if.data  = '0;
    rst_n         = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_calendar_edges();
    test_weekend_settings();
    test_century_spans();
    test_output_backpressure();
    test_random_spans();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d spans (%0d with bad dates, %0d empty), longest %0d days",
             requests_sent, invalid_sent, empty_sent, longest_span);
    $display("%0d weekend settings written, %0d results checked, %0d faults",
             mask_writes, results_seen, fault_count);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
